// File: rtl/murmurhash2_stream_core_assert.svh
// Assertion macros shared by the hash core modules
`ifndef MURMURHASH2_STREAM_CORE_ASSERT_SVH
`define MURMURHASH2_STREAM_CORE_ASSERT_SVH

// same-cycle implication
`define MH2_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mh2 assertion failed");

// next-cycle implication
`define MH2_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mh2 assertion failed");

`endif

// File: rtl/mh2_pkg.sv
// Constants, types and helpers for the MurmurHash2 stream core
`default_nettype none
package mh2_pkg;

   localparam logic [31:0] MH_MULT       = 32'h5bd1e995;
   localparam int unsigned MH_SHIFT      = 24;
   localparam int unsigned MH_FIN1       = 13;
   localparam int unsigned MH_FIN2       = 15;
   localparam logic [31:0] MH_SEED_RESET = 32'h6263533a;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // request tdata layout, lowest field first
   localparam int unsigned WORD_LSB    = 0;
   localparam int unsigned COUNT_LSB   = 32;
   localparam int unsigned LENGTH_LSB  = 35;
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned RSP_TDATA_W = 32;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_TAIL,
      KIND_FULL
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        ends;
      logic [31:0] mix;     // mixed k for a full word, masked bytes for a tail
      logic [31:0] length;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MIX,
      ST_FIN_A,
      ST_FIN_M,
      ST_FIN_B
   } back_state_type;

   function automatic logic [31:0] tail_mask(input logic [2:0] count);
      logic [31:0] mask;
      begin
         unique case (count)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
         endcase
         return mask;
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/mh2_front.sv
// Front end: accepts items, classifies them and pre-mixes full words
`default_nettype none
module mh2_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mh2_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   output logic                                 push_valid,
   output mh2_pkg::entry_type                   push_entry,
   input  logic                                 push_ready
);
   import mh2_pkg::*;

   logic        a_valid_ff;
   logic [31:0] a_k_ff;
   logic [31:0] a_word_ff;
   kind_type    a_kind_ff;
   logic        a_ends_ff;
   logic [31:0] a_len_ff;

   logic        b_valid_ff;
   entry_type   b_entry_ff;

   logic [31:0] word;
   logic [2:0]  count;
   kind_type    kind_in;
   logic [31:0] a_k_in;
   logic [31:0] k_shr;
   logic [31:0] b_k_in;
   logic        a_free;
   logic        b_free;
   logic        accept;
   logic        a_move;

   assign word  = req_tdata[WORD_LSB +: 32];
   assign count = req_tdata[COUNT_LSB +: 3];

   always_comb begin
      priority if (count == 3'd0) begin
         kind_in = KIND_EMPTY;
      end else if (count >= 3'd4) begin
         kind_in = KIND_FULL;
      end else begin
         kind_in = KIND_TAIL;
      end
   end

   assign a_k_in = word * MH_MULT;
   assign k_shr  = a_k_ff ^ (a_k_ff >> MH_SHIFT);
   assign b_k_in = k_shr * MH_MULT;

   assign b_free     = !b_valid_ff || push_ready;
   assign a_free     = !a_valid_ff || b_free;
   assign a_move     = a_valid_ff && b_free;
   assign req_tready = a_free;
   assign accept     = req_tvalid && a_free;
   assign push_valid = b_valid_ff;
   assign push_entry = b_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_k_ff    <= a_k_in;
         a_word_ff <= word & tail_mask(count);
         a_kind_ff <= kind_in;
         a_ends_ff <= req_tlast || (kind_in != KIND_FULL);
         a_len_ff  <= req_tdata[LENGTH_LSB +: 32];
      end
      if (a_move) begin
         b_entry_ff.kind   <= a_kind_ff;
         b_entry_ff.ends   <= a_ends_ff;
         b_entry_ff.mix    <= (a_kind_ff == KIND_FULL) ? b_k_in : a_word_ff;
         b_entry_ff.length <= a_len_ff;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mh2_queue.sv
// Short item queue between front and back ends
`default_nettype none
module mh2_queue #(
   parameter int unsigned DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mh2_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output mh2_pkg::entry_type pop_entry,
   input  logic               pop
);
   import mh2_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `include "murmurhash2_stream_core_assert.svh"

   `MH2_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT)

endmodule
`default_nettype wire

// File: rtl/mh2_back.sv
// Back end: folds items into the running hash, finalises and holds the result
`default_nettype none
module mh2_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data,
   input  logic                            pop_valid,
   input  mh2_pkg::entry_type              pop_entry,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mh2_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mh2_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0]    seed_ff;
   logic [31:0]    h_ff, h_in;
   logic           in_msg_ff, in_msg_in;
   kind_type       kind_ff;
   logic           ends_ff;
   logic [31:0]    mix_ff;
   logic           load_entry;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_data_ff;
   logic           out_load;
   logic [31:0]    h_start;

   always_comb begin
      h_start = in_msg_ff ? h_ff : (seed_ff ^ pop_entry.length);
      if (pop_entry.kind == KIND_TAIL) begin
         h_start = h_start ^ pop_entry.mix;
      end
   end

   always_comb begin
      state_in   = state_ff;
      h_in       = h_ff;
      in_msg_in  = in_msg_ff;
      pop        = 1'b0;
      load_entry = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop        = 1'b1;
               load_entry = 1'b1;
               h_in       = h_start;
               in_msg_in  = !pop_entry.ends;
               state_in   = (pop_entry.kind == KIND_EMPTY) ? ST_FIN_A : ST_MUL;
            end
         end
         ST_MUL: begin
            h_in     = h_ff * MH_MULT;
            state_in = (kind_ff == KIND_FULL) ? ST_MIX : ST_FIN_A;
         end
         ST_MIX: begin
            h_in     = h_ff ^ mix_ff;
            state_in = ends_ff ? ST_FIN_A : ST_IDLE;
         end
         ST_FIN_A: begin
            h_in     = h_ff ^ (h_ff >> MH_FIN1);
            state_in = ST_FIN_M;
         end
         ST_FIN_M: begin
            h_in     = h_ff * MH_MULT;
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            if (!out_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= MH_SEED_RESET;
         h_ff         <= '0;
         in_msg_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         in_msg_ff    <= in_msg_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_entry) begin
         kind_ff <= pop_entry.kind;
         ends_ff <= pop_entry.ends;
         mix_ff  <= pop_entry.mix;
      end
      if (out_load) begin
         out_data_ff <= h_ff ^ (h_ff >> MH_FIN2);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `include "murmurhash2_stream_core_assert.svh"

   `MH2_ASSERT_NOW(a_pop_has_item, clock, reset, pop, pop_valid)
   `MH2_ASSERT_NOW(a_pop_only_idle, clock, reset, state_ff != ST_IDLE, !pop)
   `MH2_ASSERT_NOW(a_rsp_from_final, clock, reset, $rose(rsp_tvalid),
                   $past(state_ff) == ST_FIN_B)

endmodule
`default_nettype wire

// File: rtl/murmurhash2_stream_core.sv
// MurmurHash2 (32-bit) stream core: top level
//
// req_*: message words, four bytes little-endian, byte 0 in bits 7:0 of the
//   word. tdata holds data_word, byte_count and message_length; tlast ends a
//   message. A byte count below four ends the message as well; a count of
//   zero on a message's first item gives the hash of an empty message.
// rsp_*: one finalised 32-bit hash per message.
// csr_*: seed write; only while the core is idle. It is used at the start
//   of each message, XORed with message_length.
// The front end takes an item a cycle while req_tready is high and
// pre-mixes full words in two multiplier stages; a small queue feeds the
// back end, whose single shared multiply loop on the running hash pops an
// item only when idle. A full word multiplies the hash, then XORs in the
// mixed word; a tail XORs in its bytes, then multiplies; the ending item
// then shift-XORs, multiplies and shift-XORs into the output register.
// The result sits in an output register: when rsp_tready is low the core
// keeps hashing until the next result is ready, then waits; the queue fills
// and req_tready drops. Reset empties the pipeline, closes any open
// message and sets the seed to 0x6263533a.
`default_nettype none
module murmurhash2_stream_core #(
   parameter int unsigned QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_word[31:0], byte_count[34:32], message_length[66:35], zero pad
   input  logic [mh2_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hash_value[31:0]
   output logic [mh2_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data
);
   import mh2_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop;
   entry_type pop_entry;

   mh2_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   mh2_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   mh2_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the MurmurHash2 stream core
`timescale 1ns / 100ps
module tb;
   import mh2_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned LIMIT_CYCLES  = 400000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [31:0]            csr_wr_data;

   // hash model state
   logic [31:0] cur_seed;
   logic [31:0] acc_hash;
   logic        msg_open;
   logic [31:0] hash_expect_q[$];
   logic [31:0] want_hash;

   int unsigned req_calm;
   int unsigned rsp_calm;
   int unsigned n_items_sent;
   int unsigned n_hashes;
   int unsigned n_seeds;
   int unsigned n_fail;
   int unsigned cycle_count;

   murmurhash2_stream_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones, and now and then a calm stretch with none
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 80);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // advance the hash model by one accepted item; a closed message queues its hash
   function automatic void absorb_item(input logic [31:0] word, input logic [2:0] count,
                                       input logic last, input logic [31:0] length);
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] mask;
      logic [2:0]  n;
      logic        done;
      n = (count > 3'd4) ? 3'd4 : count;
      h = msg_open ? acc_hash : (cur_seed ^ length);
      if (n == 3'd4) begin
         k = word * MH_MULT;
         k = k ^ (k >> MH_SHIFT);
         k = k * MH_MULT;
         h = (h * MH_MULT) ^ k;
         done = last;
      end else begin
         if (n != 3'd0) begin
            mask = 32'hffff_ffff >> (8 * (4 - n));
            h = (h ^ (word & mask)) * MH_MULT;
         end
         done = 1'b1;
      end
      if (done) begin
         h = h ^ (h >> MH_FIN1);
         h = h * MH_MULT;
         h = h ^ (h >> MH_FIN2);
         hash_expect_q.push_back(h);
         acc_hash = '0;
         msg_open = 1'b0;
      end else begin
         acc_hash = h;
         msg_open = 1'b1;
      end
   endfunction

   // entered and left at a rising edge
   task automatic send_item(input logic [31:0] word, input logic [2:0] count,
                            input logic last, input logic [31:0] length);
      logic [REQ_TDATA_W-1:0] bus;
      int unsigned gap;
      bus = '0;
      bus[WORD_LSB +: 32]   = word;
      bus[COUNT_LSB +: 3]   = count;
      bus[LENGTH_LSB +: 32] = length;
      req_tvalid <= 1'b1;
      req_tdata  <= bus;
      req_tlast  <= last;
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
      absorb_item(word, count, last, length);
      n_items_sent++;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every pending hash come out, then give the core time to go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (hash_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      cur_seed = value;
      n_seeds++;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_directed_basics();
      send_item(32'h1234_5678, 3'd0, 1'b0, 32'd0);           // empty message
      send_item(32'hdead_beef, 3'd1, 1'b0, 32'd1);           // tail bytes, junk above
      send_item(32'hdead_beef, 3'd2, 1'b0, 32'd2);
      send_item(32'hdead_beef, 3'd3, 1'b1, 32'd3);
      send_item(32'h0000_0000, 3'd4, 1'b1, 32'd4);
      send_item(32'hffff_ffff, 3'd4, 1'b1, 32'hffff_ffff);
      send_item(32'ha5a5_5a5a, 3'd5, 1'b1, 32'd4);           // oversize counts act as four
      send_item(32'h5a5a_a5a5, 3'd6, 1'b1, 32'd4);
      send_item(32'h0f0f_f0f0, 3'd7, 1'b1, 32'h8000_0000);
      // three words and a two-byte tail
      send_item(32'h6c6c_6548, 3'd4, 1'b0, 32'd14);
      send_item(32'h6f77_206f, 3'd4, 1'b0, 32'hffff_ffff);  // length ignored here
      send_item(32'h2164_6c72, 3'd4, 1'b0, 32'd0);
      send_item(32'hffff_0a0d, 3'd2, 1'b0, 32'd7);
      // two words closed by a zero-byte item
      send_item(32'h0123_4567, 3'd4, 1'b0, 32'd8);
      send_item(32'h89ab_cdef, 3'd4, 1'b0, 32'd8);
      send_item(32'hffff_ffff, 3'd0, 1'b0, 32'd8);
      send_item(32'h0000_6261, 3'd2, 1'b1, 32'd100);         // length does not match
   endtask

   task automatic test_seed_extremes();
      settle();
      write_seed(32'h0000_0000);
      send_item(32'h0000_0000, 3'd0, 1'b1, 32'd0);
      send_item(32'h8000_0001, 3'd4, 1'b1, 32'h0000_0004);
      settle();
      write_seed(32'hffff_ffff);
      send_item(32'h0000_0000, 3'd0, 1'b1, 32'd0);
      send_item(32'h8000_0001, 3'd4, 1'b1, 32'hffff_ffff);
   endtask

   // the new seed must leave the open message alone
   task automatic test_seed_mid_message();
      settle();
      send_item(32'h7654_3210, 3'd4, 1'b0, 32'd6);
      settle();
      write_seed(32'h1357_9bdf);
      send_item(32'h0000_3322, 3'd2, 1'b0, 32'd6);
   endtask

   task automatic test_random_messages(input logic [31:0] seed_value,
                                       input int unsigned n_items);
      int unsigned start;
      int unsigned len;
      int unsigned nfull;
      int unsigned rem;
      int unsigned r;
      int unsigned i;
      logic [31:0] len_field;
      logic [2:0]  cnt;
      logic        flag;
      logic        zero_end;
      logic        first;
      settle();
      write_seed(seed_value);
      start = n_items_sent;
      while (n_items_sent - start < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            // noise: arbitrary items until the message closes
            first = 1'b1;
            while (first || msg_open) begin
               first = 1'b0;
               cnt   = 3'($urandom_range(0, 7));
               flag  = 1'($urandom_range(0, 1));
               send_item($urandom, cnt, flag, $urandom);
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70)
               len = $urandom_range(0, 16);
            else if (r < 95)
               len = $urandom_range(17, 64);
            else
               len = $urandom_range(65, 200);
            if ($urandom_range(0, 9) == 0)
               len_field = $urandom;
            else
               len_field = len;
            nfull    = len / 4;
            rem      = len % 4;
            zero_end = (rem == 0) && (len != 0) && ($urandom_range(0, 4) == 0);
            if (len == 0) begin
               flag = 1'($urandom_range(0, 1));
               send_item($urandom, 3'd0, flag, len_field);
            end
            for (i = 0; i < nfull; i++) begin
               if ($urandom_range(0, 9) == 0)
                  cnt = 3'($urandom_range(5, 7));
               else
                  cnt = 3'd4;
               flag = (i == nfull - 1) && (rem == 0) && !zero_end;
               send_item($urandom, cnt, flag, (i == 0) ? len_field : $urandom);
            end
            flag = 1'($urandom_range(0, 1));
            if (rem != 0) begin
               cnt = 3'(rem);
               send_item($urandom, cnt, flag, (nfull == 0) ? len_field : $urandom);
            end else if (zero_end) begin
               send_item($urandom, 3'd0, flag, $urandom);
            end
         end
      end
   endtask

   // result side: sample at the falling edge, the transfer completes at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hash_expect_q.size() == 0) begin
            $display("%0t: hash %08h arrived with none expected", $time, rsp_tdata);
            n_fail++;
         end else begin
            want_hash = hash_expect_q.pop_front();
            n_hashes++;
            if (rsp_tdata !== want_hash) begin
               $display("%0t: hash_value expected %08h, got %08h",
                        $time, want_hash, rsp_tdata);
               n_fail++;
            end
         end
      end
   end

   initial begin : rsp_backpressure
      int unsigned hold;
      int unsigned stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         stall = pick_gap(rsp_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: run timed out with %0d hashes pending", $time, hash_expect_q.size());
         $display("murmurhash2_stream_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      cur_seed     = MH_SEED_RESET;
      acc_hash     = '0;
      msg_open     = 1'b0;
      req_calm     = 0;
      rsp_calm     = 0;
      n_items_sent = 0;
      n_hashes     = 0;
      n_seeds      = 0;
      n_fail       = 0;
      cycle_count  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_seed_extremes();
      test_seed_mid_message();
      test_random_messages($urandom, 340);
      test_random_messages(32'h0000_0000, 330);
      test_random_messages(32'hffff_ffff, 330);
      test_random_messages(MH_SEED_RESET, 330);
      settle();

      $display("Sent %0d items, checked %0d hashes under %0d seed writes plus the reset seed",
               n_items_sent, n_hashes, n_seeds);
      $display("Covered empty, tail, oversize-count, mid-message seed and length-mismatch cases");
      if (n_fail == 0)
         $display("murmurhash2_stream_core: match");
      else
         $display("murmurhash2_stream_core: mismatch");
      $finish;
   end

endmodule
